@@ rtl/dsrs_pkg.sv @@
// ============================================================================
// dsrs_pkg: shared definitions for the dual-slot record selector
// Record layout constants, configuration register codes, the configuration
// bundle, the per-record verdict and the byte-wide reflected CRC-32 step.
// ============================================================================
`default_nettype none

package dsrs_pkg;

  // Record layout and check constants.
  localparam int unsigned HDR_BYTES         = 48;
  localparam int unsigned PAYLOAD_LEN_W     = 13;
  // Position counter must hold the header size plus the largest length code.
  localparam int unsigned POS_W             = 14;
  localparam int unsigned MAX_PAYLOAD_BYTES = 4096;

  localparam logic [31:0] REC_MAGIC       = 32'h5650_4D52;
  localparam logic [31:0] REC_FORMAT_WORD = 32'h0030_0001;
  localparam logic [31:0] REC_COMMIT      = 32'h434F_4D54;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] LEGACY_FP       = 32'hFFFF_FFFF;

  // Header word indexes.
  localparam logic [3:0] HW_MAGIC    = 4'd0;
  localparam logic [3:0] HW_FORMAT   = 4'd1;
  localparam logic [3:0] HW_LENGTH   = 4'd2;
  localparam logic [3:0] HW_SEQUENCE = 4'd3;
  localparam logic [3:0] HW_CRC      = 4'd4;
  localparam logic [3:0] HW_FP       = 4'd5;
  localparam logic [3:0] HW_PRODUCT  = 4'd6;
  localparam logic [3:0] HW_HARDWARE = 4'd7;
  localparam logic [3:0] HW_MOTOR    = 4'd8;
  localparam logic [3:0] HW_SCHEMA   = 4'd9;
  localparam logic [3:0] HW_COMMIT   = 4'd10;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARDWARE_PROF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_PROF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINGERPRINT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_VERSION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_LEGACY   = 3'd6;

  localparam logic [PAYLOAD_LEN_W-1:0] PAYLOAD_LEN_RESET = 13'd64;

  typedef struct packed {
    logic [PAYLOAD_LEN_W-1:0] payload_length;
    logic [31:0]              product_code;
    logic [31:0]              hardware_profile;
    logic [31:0]              motor_profile;
    logic [31:0]              config_fingerprint;
    logic [31:0]              schema_version;
    logic                     allow_legacy_fingerprint;
  } cfg_t;

  // Verdict of a record, valid in the cycle its final byte is processed.
  typedef struct packed {
    logic        ok;
    logic [31:0] sequence_num;
  } verdict_t;

  // One byte of a reflected CRC-32, eight shift steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dsrs_record_parser.sv @@
// ============================================================================
// dsrs_record_parser: header check and payload CRC of one record
// Consumes one record byte per strobe, checks each header word as it
// completes, runs the payload CRC and reports the verdict on the final byte.
// ============================================================================
`default_nettype none

module dsrs_record_parser
  import dsrs_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = dsrs_pkg::MAX_PAYLOAD_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output verdict_t        verdict
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]      word_assembly, word_assembly_next;
  logic             header_pass, header_pass_next;
  logic [31:0]      stored_crc, stored_crc_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [31:0]      pending_seq, pending_seq_next;

  logic [POS_W-1:0] total_bytes;
  logic             len_ok;
  logic             in_header, in_record;
  logic [3:0]       word_idx;
  logic             word_ok;

  assign total_bytes = POS_W'(HDR_BYTES) + POS_W'(cfg.payload_length);
  assign len_ok      = (cfg.payload_length != '0) &&
                       (int'(cfg.payload_length) <= MAX_PAYLOAD_BYTES);
  assign in_header   = byte_position < POS_W'(HDR_BYTES);
  assign in_record   = byte_position < total_bytes;
  assign word_idx    = byte_position[5:2];

  always_comb begin
    word_assembly_next = word_assembly;
    header_pass_next   = header_pass;
    stored_crc_next    = stored_crc;
    running_crc_next   = running_crc;
    pending_seq_next   = pending_seq;
    byte_position_next = byte_position;
    word_ok            = 1'b1;

    if (in_header) begin
      word_assembly_next = {data_byte, word_assembly[31:8]};
      if (byte_position[1:0] == 2'd3) begin
        case (word_idx)
          HW_MAGIC:    word_ok = (word_assembly_next == REC_MAGIC);
          HW_FORMAT:   word_ok = (word_assembly_next == REC_FORMAT_WORD);
          HW_LENGTH:   word_ok = (word_assembly_next ==
                                  {{(32-PAYLOAD_LEN_W){1'b0}}, cfg.payload_length});
          HW_SEQUENCE: pending_seq_next = word_assembly_next;
          HW_CRC:      stored_crc_next  = word_assembly_next;
          HW_FP:       word_ok = (word_assembly_next == cfg.config_fingerprint) ||
                                 (cfg.allow_legacy_fingerprint &&
                                  (word_assembly_next == LEGACY_FP));
          HW_PRODUCT:  word_ok = (word_assembly_next == cfg.product_code);
          HW_HARDWARE: word_ok = (word_assembly_next == cfg.hardware_profile);
          HW_MOTOR:    word_ok = (word_assembly_next == cfg.motor_profile);
          HW_SCHEMA:   word_ok = (word_assembly_next == cfg.schema_version);
          HW_COMMIT:   word_ok = (word_assembly_next == REC_COMMIT);
          default:     word_ok = (word_assembly_next == ~REC_COMMIT);
        endcase
        if (!word_ok) begin
          header_pass_next = 1'b0;
        end
      end
    end else if (in_record) begin
      running_crc_next = crc32_byte(running_crc, data_byte);
    end

    // The position saturates at the record length; trailing bytes are ignored.
    if (in_record) begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  assign verdict.ok = len_ok && header_pass_next &&
                      (byte_position_next == total_bytes) &&
                      (~running_crc_next == stored_crc_next);
  assign verdict.sequence_num = pending_seq_next;

  always_ff @(posedge clk) begin
    if (rst || (byte_en && last_byte)) begin
      byte_position <= '0;
      word_assembly <= '0;
      header_pass   <= 1'b1;
      stored_crc    <= '0;
      running_crc   <= CRC_INIT;
      pending_seq   <= '0;
    end else if (byte_en) begin
      byte_position <= byte_position_next;
      word_assembly <= word_assembly_next;
      header_pass   <= header_pass_next;
      stored_crc    <= stored_crc_next;
      running_crc   <= running_crc_next;
      pending_seq   <= pending_seq_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dual_slot_record_selector_top.sv @@
// ============================================================================
// dual_slot_record_selector_top: A/B record slot selector with CRC-32 check
// Streams the stored bytes of slot 0 and then slot 1, validates each record
// and reports which slot holds the newest valid record.
// ============================================================================
// Usage: bytes arrive on the input channel (in_valid, in_stall, slot_index,
// data_byte, last_byte), one request per byte, slot 0's record first and then
// slot 1's record, last_byte marking the end of each record. A request is
// taken at a clock edge where in_valid is high and in_stall is low. Only the
// final byte of a slot 1 record produces a result; it appears on the output
// channel (out_valid, out_stall, record_found, selected_slot,
// selected_sequence, slot0_ok, slot1_ok) and is taken when out_valid is high
// and out_stall is low. The end of a slot 0 record produces no result.
// An accepted final byte passes one input register stage, then the header
// check and an unrolled byte-wide CRC-32 feeding the result register.
// Throughput is one byte per cycle while in_stall is low. While the receiver
// stalls a pending result, bytes that make no result keep flowing; the next
// slot 1 final byte waits in the input stage and in_stall rises. cfg_ready is
// always high. The user must write configuration registers through
// cfg_valid/cfg_ready/cfg_index/cfg_data while the block is idle, which it
// does not enforce. Reset restores defaults and clears flags and record state.
// ============================================================================
`default_nettype none

module dual_slot_record_selector_top
  import dsrs_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = dsrs_pkg::MAX_PAYLOAD_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  // Byte input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 slot_index,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      record_found,
  output logic                      selected_slot,
  output logic [31:0]               selected_sequence,
  output logic                      slot0_ok,
  output logic                      slot1_ok
);

  cfg_t cfg;

  // Input register stage.
  logic       s1_valid;
  logic       s1_slot;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Slot 0 outcome held until slot 1's record ends.
  logic        slot0_valid;
  logic [31:0] slot0_seq;

  verdict_t    verdict;
  logic        makes_result;
  logic        out_free;
  logic        advance;
  logic        in_take;
  logic        pick1;
  logic [31:0] seq_diff;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_length           <= PAYLOAD_LEN_RESET;
      cfg.product_code             <= '0;
      cfg.hardware_profile         <= '0;
      cfg.motor_profile            <= '0;
      cfg.config_fingerprint       <= '0;
      cfg.schema_version           <= '0;
      cfg.allow_legacy_fingerprint <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAYLOAD_LENGTH: cfg.payload_length     <= cfg_data[PAYLOAD_LEN_W-1:0];
        REG_PRODUCT_CODE:   cfg.product_code       <= cfg_data;
        REG_HARDWARE_PROF:  cfg.hardware_profile   <= cfg_data;
        REG_MOTOR_PROF:     cfg.motor_profile      <= cfg_data;
        REG_FINGERPRINT:    cfg.config_fingerprint <= cfg_data;
        REG_SCHEMA_VERSION: cfg.schema_version     <= cfg_data;
        REG_ALLOW_LEGACY:   cfg.allow_legacy_fingerprint <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A byte in the input stage moves on unless it needs the result register
  // and that register still holds a result the receiver has not taken.
  assign makes_result = s1_last && s1_slot;
  assign out_free     = !out_valid || !out_stall;
  assign advance      = s1_valid && (!makes_result || out_free);
  assign in_stall     = s1_valid && !advance;
  assign in_take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_slot <= slot_index;
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  dsrs_record_parser #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  // Slot 0 entry: written when a slot 0 record ends, cleared after a decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_valid <= 1'b0;
      slot0_seq   <= '0;
    end else if (advance && s1_last) begin
      if (s1_slot) begin
        slot0_valid <= 1'b0;
        slot0_seq   <= '0;
      end else begin
        slot0_valid <= verdict.ok;
        slot0_seq   <= verdict.sequence_num;
      end
    end
  end

  // Slot 1 wins when valid and either slot 0 is invalid or its sequence is
  // ahead by a positive wrap-around difference.
  assign seq_diff = verdict.sequence_num - slot0_seq;
  assign pick1    = verdict.ok &&
                    (!slot0_valid || ((seq_diff != '0) && !seq_diff[31]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && makes_result) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && makes_result) begin
      record_found  <= slot0_valid || verdict.ok;
      selected_slot <= pick1;
      if (pick1) begin
        selected_sequence <= verdict.sequence_num;
      end else if (slot0_valid) begin
        selected_sequence <= slot0_seq;
      end else begin
        selected_sequence <= '0;
      end
      slot0_ok <= slot0_valid;
      slot1_ok <= verdict.ok;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the dual-slot record selector
// Builds slot 0 and slot 1 records byte by byte, sends them with random gaps
// and output stalls, and compares each slot decision with an in-bench model.
// ============================================================================

module tb_top;
  import dsrs_pkg::*;

  // Index 7 has no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_BYTES   = 1050;
  localparam int unsigned RANDOM_RESULTS = 40;

  // Ways in which a generated record can differ from a clean one.
  typedef enum {
    FLAW_NONE, FLAW_HEADER, FLAW_PAYLOAD, FLAW_SHORT, FLAW_TRAILING,
    FLAW_LEGACY, FLAW_NOISE
  } record_flaw_e;

  // One slot decision as it appears on the result port.
  typedef struct {
    bit        found;
    bit        slot;
    bit [31:0] seq;
    bit        ok0;
    bit        ok1;
  } decision_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 slot_index = 1'b0;
  logic [7:0]           data_byte  = '0;
  logic                 last_byte  = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 record_found;
  logic                 selected_slot;
  logic [31:0]          selected_sequence;
  logic                 slot0_ok;
  logic                 slot1_ok;

  dual_slot_record_selector_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .slot_index        (slot_index),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .record_found      (record_found),
    .selected_slot     (selected_slot),
    .selected_sequence (selected_sequence),
    .slot0_ok          (slot0_ok),
    .slot1_ok          (slot1_ok)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state. The shadow configuration follows every accepted register
  // write, and the record tracker mirrors what the block has seen of the
  // record in flight, so a decision can be worked out the moment the final
  // byte of a slot 1 record is accepted.
  // --------------------------------------------------------------------------
  cfg_t        shadow_cfg;
  bit [31:0]   rec_pos;
  bit [31:0]   rec_word;
  bit          rec_hdr_ok;
  bit [31:0]   rec_crc_field;
  bit [31:0]   rec_crc;
  bit [31:0]   rec_seq;
  bit          slot_ok [2];
  bit [31:0]   slot_seq [2];
  decision_t   expected_decisions [$];

  int unsigned bytes_sent     = 0;
  int unsigned decisions_made = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  // Set for the closing stretch of the run: no gaps and no stalls there.
  bit          quiet          = 1'b0;

  function automatic bit [31:0] crc_update(input bit [31:0] crc, input bit [7:0] b);
    bit [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void restart_record();
    rec_pos       = '0;
    rec_word      = '0;
    rec_hdr_ok    = 1'b1;
    rec_crc_field = '0;
    rec_crc       = CRC_INIT;
    rec_seq       = '0;
  endfunction

  // Follows one accepted byte. Header words are judged as their fourth byte
  // lands, payload bytes feed the CRC, and anything past the expected end is
  // ignored with the position held. A final byte files the verdict under the
  // slot that byte names; on slot 1 the decision is queued and both slot
  // entries are wiped for the next pair.
  task automatic absorb_record_byte(input bit s, input bit [7:0] b, input bit l);
    bit [31:0] total;
    bit [31:0] gap;
    bit        word_ok;
    bit        good;
    bit        pick1;
    decision_t d;
    total = HDR_BYTES + shadow_cfg.payload_length;
    if (rec_pos < HDR_BYTES) begin
      rec_word = {b, rec_word[31:8]};
      if (rec_pos[1:0] == 2'b11) begin
        word_ok = 1'b1;
        case (rec_pos[5:2])
          HW_MAGIC:    word_ok = (rec_word == REC_MAGIC);
          HW_FORMAT:   word_ok = (rec_word == REC_FORMAT_WORD);
          HW_LENGTH:   word_ok = (rec_word == {19'd0, shadow_cfg.payload_length});
          HW_SEQUENCE: rec_seq = rec_word;
          HW_CRC:      rec_crc_field = rec_word;
          HW_FP:       word_ok = (rec_word == shadow_cfg.config_fingerprint) ||
                                 (shadow_cfg.allow_legacy_fingerprint &&
                                  rec_word == LEGACY_FP);
          HW_PRODUCT:  word_ok = (rec_word == shadow_cfg.product_code);
          HW_HARDWARE: word_ok = (rec_word == shadow_cfg.hardware_profile);
          HW_MOTOR:    word_ok = (rec_word == shadow_cfg.motor_profile);
          HW_SCHEMA:   word_ok = (rec_word == shadow_cfg.schema_version);
          HW_COMMIT:   word_ok = (rec_word == REC_COMMIT);
          default:     word_ok = (rec_word == ~REC_COMMIT);
        endcase
        if (!word_ok) rec_hdr_ok = 1'b0;
      end
    end else if (rec_pos < total) begin
      rec_crc = crc_update(rec_crc, b);
    end
    if (rec_pos < total) rec_pos++;
    if (l) begin
      good = (shadow_cfg.payload_length >= 1) &&
             (shadow_cfg.payload_length <= MAX_PAYLOAD_BYTES) &&
             rec_hdr_ok && (rec_pos == total) && ((~rec_crc) == rec_crc_field);
      slot_ok[s]  = good;
      slot_seq[s] = rec_seq;
      restart_record();
      if (s) begin
        // Slot 1 wins on a strictly newer sequence in wrap-around order.
        gap     = slot_seq[1] - slot_seq[0];
        pick1   = slot_ok[1] && (!slot_ok[0] || (gap != 0 && !gap[31]));
        d.found = slot_ok[0] || slot_ok[1];
        d.slot  = pick1;
        d.seq   = d.found ? slot_seq[pick1] : 32'd0;
        d.ok0   = slot_ok[0];
        d.ok1   = slot_ok[1];
        expected_decisions.push_back(d);
        decisions_made++;
        slot_ok[0]  = 1'b0;
        slot_ok[1]  = 1'b0;
        slot_seq[0] = '0;
        slot_seq[1] = '0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driving. Every drive happens with a nonblocking assignment right
  // after a rising edge, and handshakes are sampled at the next rising edge,
  // so the block always sees stable inputs around the clock.
  // --------------------------------------------------------------------------
  task automatic send_byte(input bit s, input bit [7:0] b, input bit l);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    slot_index <= s;
    data_byte  <= b;
    last_byte  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_record_byte(s, b, l);
    bytes_sent++;
  endtask

  // Builds one record from the current settings, spoils it as asked, and
  // sends it. With mixed set, every byte but the last carries a random slot
  // index; only the final byte's index decides where the verdict goes.
  task automatic send_slot(input bit s, input bit [31:0] seq, input record_flaw_e flaw,
                           input int word_sel, input bit mixed);
    bit [31:0] hdr [12];
    bit [7:0]  body [$];
    bit [7:0]  img [$];
    bit [31:0] crc;
    int        plen;
    int        w;
    int        n;
    plen = shadow_cfg.payload_length;
    crc  = CRC_INIT;
    for (int i = 0; i < plen; i++) begin
      body.push_back($urandom_range(0, 255));
      crc = crc_update(crc, body[i]);
    end
    hdr[HW_MAGIC]    = REC_MAGIC;
    hdr[HW_FORMAT]   = REC_FORMAT_WORD;
    hdr[HW_LENGTH]   = plen;
    hdr[HW_SEQUENCE] = seq;
    hdr[HW_CRC]      = ~crc;
    hdr[HW_FP]       = (flaw == FLAW_LEGACY) ? LEGACY_FP : shadow_cfg.config_fingerprint;
    hdr[HW_PRODUCT]  = shadow_cfg.product_code;
    hdr[HW_HARDWARE] = shadow_cfg.hardware_profile;
    hdr[HW_MOTOR]    = shadow_cfg.motor_profile;
    hdr[HW_SCHEMA]   = shadow_cfg.schema_version;
    hdr[HW_COMMIT]   = REC_COMMIT;
    hdr[11]          = ~REC_COMMIT;
    if (flaw == FLAW_HEADER) begin
      // The sequence word is never checked, so it is never the one spoiled.
      w = word_sel;
      if (w < 0) begin
        w = $urandom_range(0, 10);
        if (w >= HW_SEQUENCE) w++;
      end
      hdr[w] = hdr[w] ^ (32'd1 << $urandom_range(0, 31));
    end
    if (flaw == FLAW_PAYLOAD) begin
      if (plen > 0) begin
        w       = $urandom_range(0, plen - 1);
        body[w] = body[w] ^ (8'd1 << $urandom_range(0, 7));
      end else begin
        hdr[HW_CRC] = hdr[HW_CRC] ^ (32'd1 << $urandom_range(0, 31));
      end
    end
    for (int i = 0; i < 12; i++) begin
      for (int k = 0; k < 4; k++) img.push_back(hdr[i][8*k +: 8]);
    end
    for (int i = 0; i < plen; i++) img.push_back(body[i]);
    n = img.size();
    case (flaw)
      FLAW_SHORT: begin
        n = (n - 1 > 200) ? $urandom_range(1, 200) : $urandom_range(1, n - 1);
      end
      FLAW_TRAILING: begin
        repeat ($urandom_range(1, 6)) img.push_back($urandom_range(0, 255));
        n = img.size();
      end
      FLAW_NOISE: begin
        img.delete();
        repeat ($urandom_range(1, 60)) img.push_back($urandom_range(0, 255));
        n = img.size();
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      send_byte((i == n - 1 || !mixed) ? s : 1'($urandom_range(0, 1)), img[i], i == n - 1);
    end
  endtask

  task automatic send_pair(input bit [31:0] seq0, input record_flaw_e flaw0,
                           input bit [31:0] seq1, input record_flaw_e flaw1);
    send_slot(1'b0, seq0, flaw0, -1, 1'b0);
    send_slot(1'b1, seq1, flaw1, -1, 1'b0);
  endtask

  // Lets every queued decision drain, then waits out the pipeline so a byte
  // that makes no result has also cleared the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAYLOAD_LENGTH: shadow_cfg.payload_length           = data[PAYLOAD_LEN_W-1:0];
      REG_PRODUCT_CODE:   shadow_cfg.product_code             = data;
      REG_HARDWARE_PROF:  shadow_cfg.hardware_profile         = data;
      REG_MOTOR_PROF:     shadow_cfg.motor_profile            = data;
      REG_FINGERPRINT:    shadow_cfg.config_fingerprint       = data;
      REG_SCHEMA_VERSION: shadow_cfg.schema_version           = data;
      REG_ALLOW_LEGACY:   shadow_cfg.allow_legacy_fingerprint = data[0];
      default: ;
    endcase
  endtask

  // Writes every register; bits above a narrow register's width carry noise.
  task automatic apply_config(input cfg_t c, input bit poke_unmapped);
    wait_idle();
    write_reg(REG_PAYLOAD_LENGTH, ($urandom() & 32'hFFFF_E000) | c.payload_length);
    write_reg(REG_PRODUCT_CODE, c.product_code);
    write_reg(REG_HARDWARE_PROF, c.hardware_profile);
    write_reg(REG_MOTOR_PROF, c.motor_profile);
    write_reg(REG_FINGERPRINT, c.config_fingerprint);
    write_reg(REG_SCHEMA_VERSION, c.schema_version);
    write_reg(REG_ALLOW_LEGACY, ($urandom() & 32'hFFFF_FFFE) | c.allow_legacy_fingerprint);
    if (poke_unmapped) write_reg(REG_UNMAPPED, $urandom());
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [31:0] pick_id();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.payload_length           = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    c.product_code             = pick_id();
    c.hardware_profile         = pick_id();
    c.motor_profile            = pick_id();
    c.config_fingerprint       = pick_id();
    c.schema_version           = pick_id();
    c.allow_legacy_fingerprint = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic record_flaw_e pick_flaw();
    int r;
    r = $urandom_range(0, 11);
    return (r < 6) ? FLAW_NONE : record_flaw_e'(r - 5);
  endfunction

  // Sequences cluster around the wrap points, where the ordering is subtle.
  function automatic bit [31:0] pick_sequence();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFF0 + $urandom_range(0, 31);
      1:       return 32'h7FFF_FFF0 + $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [31:0] next_sequence(input bit [31:0] seq0);
    case ($urandom_range(0, 4))
      0:       return seq0 + $urandom_range(1, 4);
      1:       return seq0 - $urandom_range(1, 4);
      2:       return seq0;
      3:       return seq0 ^ 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, then a field-by-field comparison of
  // every accepted result with the oldest decision still waiting.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    decision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_decisions.size() == 0) begin
        $error("result arrived with no slot 1 record behind it");
        mismatches++;
      end else begin
        want = expected_decisions.pop_front();
        if (record_found !== want.found) begin
          $error("record_found: expected %0d, actual %0d", want.found, record_found);
          mismatches++;
        end
        if (selected_slot !== want.slot) begin
          $error("selected_slot: expected %0d, actual %0d", want.slot, selected_slot);
          mismatches++;
        end
        if (selected_sequence !== want.seq) begin
          $error("selected_sequence: expected %h, actual %h", want.seq, selected_sequence);
          mismatches++;
        end
        if (slot0_ok !== want.ok0) begin
          $error("slot0_ok: expected %0d, actual %0d", want.ok0, slot0_ok);
          mismatches++;
        end
        if (slot1_ok !== want.ok1) begin
          $error("slot1_ok: expected %0d, actual %0d", want.ok1, slot1_ok);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here rather than hanging the simulator.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: 64-byte payload and all identifiers zero.
  task automatic test_reset_defaults();
    send_pair(32'd1, FLAW_NONE, 32'd2, FLAW_NONE);
    send_pair(32'd5, FLAW_NONE, 32'd3, FLAW_NONE);
  endtask

  // Every register at its top value, then at its bottom value, with a write
  // to the unmapped index each time.
  task automatic test_config_registers();
    cfg_t c;
    c.payload_length           = MAX_PAYLOAD_BYTES;
    c.product_code             = 32'hFFFF_FFFF;
    c.hardware_profile         = 32'hFFFF_FFFF;
    c.motor_profile            = 32'hFFFF_FFFF;
    c.config_fingerprint       = 32'hFFFF_FFFF;
    c.schema_version           = 32'hFFFF_FFFF;
    c.allow_legacy_fingerprint = 1'b1;
    apply_config(c, 1'b1);
    send_pair(32'hFFFF_FFFF, FLAW_NONE, 32'h7FFF_FFFE, FLAW_NONE);
    c = '0;
    c.payload_length = 1;
    apply_config(c, 1'b1);
    send_pair(32'd0, FLAW_NONE, 32'd0, FLAW_NONE);
  endtask

  // A length of one is accepted, while a length of zero or above the supported
  // maximum spoils every record, even one whose bytes otherwise line up.
  task automatic test_length_extremes();
    cfg_t c;
    c = random_settings();
    c.payload_length = 1;
    apply_config(c, 1'b0);
    send_pair($urandom(), FLAW_NONE, $urandom(), FLAW_NONE);
    c.payload_length = 0;
    apply_config(c, 1'b0);
    send_pair($urandom(), FLAW_NONE, $urandom(), FLAW_NONE);
    c.payload_length = MAX_PAYLOAD_BYTES + 1;
    apply_config(c, 1'b0);
    send_pair($urandom(), FLAW_SHORT, $urandom(), FLAW_NONE);
    c.payload_length = 13'h1FFF;
    apply_config(c, 1'b0);
    send_pair($urandom(), FLAW_NOISE, $urandom(), FLAW_SHORT);
  endtask

  // One bad bit in each checked header word, alternating the slot hit.
  task automatic test_header_fields();
    cfg_t c;
    c = random_settings();
    c.payload_length = 3;
    apply_config(c, 1'b0);
    for (int w = 0; w < 12; w++) begin
      if (w != HW_SEQUENCE) begin
        send_slot(1'b0, $urandom(), (w % 2) ? FLAW_HEADER : FLAW_NONE, w, 1'b0);
        send_slot(1'b1, $urandom(), (w % 2) ? FLAW_NONE : FLAW_HEADER, w, 1'b0);
      end
    end
  endtask

  // An all-ones fingerprint passes only with legacy mode on.
  task automatic test_legacy_fingerprint();
    cfg_t c;
    c = random_settings();
    c.payload_length           = 4;
    c.config_fingerprint       = $urandom() & 32'h7FFF_FFFF;
    c.allow_legacy_fingerprint = 1'b0;
    apply_config(c, 1'b0);
    send_pair(32'd10, FLAW_LEGACY, 32'd11, FLAW_NONE);
    c.allow_legacy_fingerprint = 1'b1;
    apply_config(c, 1'b0);
    send_pair(32'd10, FLAW_NONE, 32'd11, FLAW_LEGACY);
    send_pair(32'd20, FLAW_LEGACY, 32'd19, FLAW_LEGACY);
  endtask

  // Bad CRC, early end, trailing bytes after a good record, and pure noise.
  task automatic test_payload_checks();
    cfg_t c;
    c = random_settings();
    c.payload_length = 8;
    apply_config(c, 1'b0);
    send_pair(32'd1, FLAW_PAYLOAD, 32'd0, FLAW_NONE);
    send_pair(32'd1, FLAW_NONE, 32'd2, FLAW_SHORT);
    send_pair(32'd3, FLAW_TRAILING, 32'd4, FLAW_TRAILING);
    send_pair(32'd5, FLAW_NOISE, 32'd6, FLAW_PAYLOAD);
  endtask

  // Wrap-around ordering: equal, half-range apart either way, just under
  // half range, across the wrap, older slot 1, and the invalid combinations.
  task automatic test_selection_order();
    cfg_t c;
    c = random_settings();
    c.payload_length = 2;
    apply_config(c, 1'b0);
    send_pair(32'd7, FLAW_NONE, 32'd7, FLAW_NONE);
    send_pair(32'd0, FLAW_NONE, 32'h8000_0000, FLAW_NONE);
    send_pair(32'h8000_0000, FLAW_NONE, 32'd0, FLAW_NONE);
    send_pair(32'd0, FLAW_NONE, 32'h7FFF_FFFF, FLAW_NONE);
    send_pair(32'hFFFF_FFFF, FLAW_NONE, 32'd0, FLAW_NONE);
    send_pair(32'd10, FLAW_NONE, 32'd9, FLAW_NONE);
    send_pair(32'd50, FLAW_HEADER, 32'd40, FLAW_NONE);
    send_pair(32'd60, FLAW_NONE, 32'd70, FLAW_PAYLOAD);
    send_pair(32'd80, FLAW_SHORT, 32'd90, FLAW_SHORT);
  endtask

  // Slot ordering oddities: slot 1 with no slot 0 before it, a later slot 0
  // record replacing an earlier one, back-to-back slot 1 records, and bytes
  // whose slot index wanders until the final byte.
  task automatic test_slot_order_quirks();
    cfg_t c;
    c = random_settings();
    c.payload_length = 2;
    apply_config(c, 1'b0);
    send_slot(1'b1, 32'd3, FLAW_NONE, -1, 1'b0);
    send_slot(1'b0, 32'd4, FLAW_NONE, -1, 1'b0);
    send_slot(1'b0, 32'd9, FLAW_HEADER, -1, 1'b0);
    send_slot(1'b1, 32'd2, FLAW_NONE, -1, 1'b0);
    send_slot(1'b1, 32'd8, FLAW_NONE, -1, 1'b0);
    send_slot(1'b0, 32'd12, FLAW_NONE, -1, 1'b1);
    send_slot(1'b1, 32'd11, FLAW_NONE, -1, 1'b1);
  endtask

  // Mostly well-formed pairs with random content and settings, plus lone
  // slot 1 records, extra slot 0 records, noise and wandering slot indexes.
  task automatic test_random_records();
    int unsigned byte_mark;
    int unsigned result_mark;
    int unsigned round;
    int          kind;
    bit          mixed;
    bit [31:0]   seq0;
    byte_mark   = bytes_sent;
    result_mark = decisions_made;
    round       = 0;
    while (bytes_sent - byte_mark < RANDOM_BYTES ||
           decisions_made - result_mark < RANDOM_RESULTS) begin
      if (round % 6 == 0) apply_config(random_settings(), $urandom_range(0, 1));
      if (bytes_sent - byte_mark > RANDOM_BYTES * 3 / 4 &&
          decisions_made - result_mark + 8 >= RANDOM_RESULTS) quiet = 1'b1;
      seq0  = pick_sequence();
      kind  = $urandom_range(0, 19);
      mixed = ($urandom_range(0, 7) == 0);
      if (kind == 16 || kind == 17) send_slot(1'b0, $urandom(), pick_flaw(), -1, mixed);
      if (kind == 19) send_slot(1'b0, 32'd0, FLAW_NOISE, -1, 1'b1);
      if (kind != 14 && kind != 15) send_slot(1'b0, seq0, pick_flaw(), -1, mixed);
      send_slot(1'b1, next_sequence(seq0), pick_flaw(), -1, mixed);
      round++;
    end
  endtask

  initial begin
    shadow_cfg                = '0;
    shadow_cfg.payload_length = PAYLOAD_LEN_RESET;
    restart_record();
    slot_ok[0]  = 1'b0;
    slot_ok[1]  = 1'b0;
    slot_seq[0] = '0;
    slot_seq[1] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_config_registers();
    test_length_extremes();
    test_header_fields();
    test_legacy_fingerprint();
    test_payload_checks();
    test_selection_order();
    test_slot_order_quirks();
    test_random_records();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ dual_slot_record_selector_top.f @@
rtl/dsrs_pkg.sv
rtl/dsrs_record_parser.sv
rtl/dual_slot_record_selector_top.sv
tb/tb_top.sv
